// ===== src/tlv_event_field_lookup_assert.svh =====
// Assertion macros for the event field lookup block.
// Depends on nothing; define NO_ASSERTIONS to leave the checks out.
`ifndef TLV_EVENT_FIELD_LOOKUP_ASSERT_SVH
`define TLV_EVENT_FIELD_LOOKUP_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define TLVEFL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tlv_event_field_lookup check failed");
`define TLVEFL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tlv_event_field_lookup check failed");
`else
`define TLVEFL_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define TLVEFL_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== src/tlvefl_pkg.sv =====
// Types and constants shared by the event field lookup modules.
// Depends on nothing.
package tlvefl_pkg;

	localparam logic [16:0] SCAN_DONE = 17'h1FFFF;
	localparam logic [15:0] OFFSET_MAX = 16'hFFFF;
	localparam logic [2:0] VALUE_BYTES = 3'd4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic [15:0] wanted_type;
		logic last_byte;
	} in_item_t;

	typedef struct packed {
		logic found;
		logic [31:0] element_value;
		logic [15:0] event_type;
		logic [15:0] event_length;
		logic truncated;
	} out_item_t;

endpackage

// ===== src/tlvefl_scan.sv =====
// Per-byte header and element scanner with its event state registers.
// Depends on tlvefl_pkg.
module tlvefl_scan (
	input logic clk,
	input logic arst_n,
	input logic advance,
	input tlvefl_pkg::in_item_t item,
	output tlvefl_pkg::out_item_t result,
	output logic at_event_start
);

	logic [15:0] offset_q;
	logic [15:0] declared_q;
	logic [15:0] kind_q;
	logic [15:0] target_q;
	logic [16:0] next_elem_q;
	logic [15:0] elem_type_q;
	logic [15:0] elem_len_q;
	logic match_q;
	logic [31:0] value_q;
	logic [2:0] value_cnt_q;

	logic first;
	logic [15:0] declared_b, kind_b, target_b, elem_type_b, elem_len_b;
	logic [16:0] next_elem_b;
	logic match_b;
	logic [31:0] value_b;
	logic [2:0] value_cnt_b;

	logic [15:0] declared_n, kind_n, elem_type_n, elem_len_n, offset_n;
	logic [16:0] next_elem_n;
	logic match_n;
	logic [31:0] value_n;
	logic [2:0] value_cnt_n;

	logic [15:0] rel;
	logic [17:0] hdr_end;
	logic [17:0] next_sum;
	logic [16:0] received;

	assign first = (offset_q == 16'd0);
	assign at_event_start = first;

	always_comb begin
		declared_b = first ? 16'd0 : declared_q;
		kind_b = first ? 16'd0 : kind_q;
		target_b = first ? item.wanted_type : target_q;
		next_elem_b = first ? 17'd4 : next_elem_q;
		elem_type_b = first ? 16'd0 : elem_type_q;
		elem_len_b = first ? 16'd0 : elem_len_q;
		match_b = first ? 1'b0 : match_q;
		value_b = first ? 32'd0 : value_q;
		value_cnt_b = first ? 3'd0 : value_cnt_q;

		declared_n = declared_b;
		kind_n = kind_b;
		next_elem_n = next_elem_b;
		elem_type_n = elem_type_b;
		elem_len_n = elem_len_b;
		match_n = match_b;
		value_n = value_b;
		value_cnt_n = value_cnt_b;

		rel = offset_q - next_elem_b[15:0];
		hdr_end = {1'b0, next_elem_b} + 18'd4;
		next_sum = {1'b0, next_elem_b} + 18'd4 + {2'b00, elem_len_b[7:0], item.data_byte};

		if (offset_q < 16'd2) begin
			kind_n = {kind_b[7:0], item.data_byte};
		end else if (offset_q < 16'd4) begin
			declared_n = {declared_b[7:0], item.data_byte};
		end else if (offset_q < declared_b) begin
			if (match_b) begin
				if (value_cnt_b < tlvefl_pkg::VALUE_BYTES) begin
					value_n = {value_b[23:0], item.data_byte};
					value_cnt_n = value_cnt_b + 3'd1;
				end
			end else if (next_elem_b != tlvefl_pkg::SCAN_DONE
					&& {1'b0, offset_q} >= next_elem_b) begin
				if (rel == 16'd0 && hdr_end > {2'b00, declared_b}) begin
					next_elem_n = tlvefl_pkg::SCAN_DONE;
				end else if (rel < 16'd2) begin
					elem_type_n = {elem_type_b[7:0], item.data_byte};
				end else if (rel < 16'd4) begin
					elem_len_n = {elem_len_b[7:0], item.data_byte};
					if (rel == 16'd3) begin
						if (elem_type_b == target_b) begin
							match_n = 1'b1;
						end else if (next_sum >= {1'b0, tlvefl_pkg::SCAN_DONE}) begin
							next_elem_n = tlvefl_pkg::SCAN_DONE;
						end else begin
							next_elem_n = next_sum[16:0];
						end
					end
				end
			end
		end

		if (item.last_byte) begin
			offset_n = 16'd0;
		end else if (offset_q != tlvefl_pkg::OFFSET_MAX) begin
			offset_n = offset_q + 16'd1;
		end else begin
			offset_n = offset_q;
		end
	end

	always_comb begin
		received = {1'b0, offset_q} + 17'd1;
		result.found = match_n;
		result.event_type = first ? {kind_n[7:0], 8'h00} : kind_n;
		if (offset_q < 16'd2) begin
			result.event_length = 16'd0;
		end else if (offset_q == 16'd2) begin
			result.event_length = {declared_n[7:0], 8'h00};
		end else begin
			result.event_length = declared_n;
		end
		result.truncated = (offset_q < 16'd3) || (received < {1'b0, result.event_length});
		result.element_value = 32'd0;
		if (match_n) begin
			case (value_cnt_n)
				3'd4: result.element_value = value_n;
				3'd3: result.element_value = {value_n[23:0], 8'h00};
				3'd2: result.element_value = {value_n[15:0], 16'h0000};
				3'd1: result.element_value = {value_n[7:0], 24'h000000};
				default: result.element_value = 32'd0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= 16'd0;
			declared_q <= 16'd0;
			kind_q <= 16'd0;
			target_q <= 16'd0;
			next_elem_q <= 17'd0;
			elem_type_q <= 16'd0;
			elem_len_q <= 16'd0;
			match_q <= 1'b0;
			value_q <= 32'd0;
			value_cnt_q <= 3'd0;
		end else if (advance) begin
			offset_q <= offset_n;
			declared_q <= declared_n;
			kind_q <= kind_n;
			target_q <= target_b;
			next_elem_q <= next_elem_n;
			elem_type_q <= elem_type_n;
			elem_len_q <= elem_len_n;
			match_q <= match_n;
			value_q <= value_n;
			value_cnt_q <= value_cnt_n;
		end
	end

endmodule

// ===== src/tlvefl_out_reg.sv =====
// Result register that holds one finished item until the receiver takes it.
// Depends on tlvefl_pkg.
module tlvefl_out_reg (
	input logic clk,
	input logic arst_n,
	input logic load,
	input tlvefl_pkg::out_item_t d,
	output logic can_load,
	output logic result_valid,
	input logic result_stall,
	output tlvefl_pkg::out_item_t result_item
);

	logic valid_q;
	tlvefl_pkg::out_item_t item_q;

	assign can_load = !valid_q || !result_stall;
	assign result_valid = valid_q;
	assign result_item = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (can_load && load) begin
			item_q <= d;
		end
	end

endmodule

// ===== src/tlv_event_field_lookup.sv =====
// Event field lookup top level: input register, byte scanner, result register.
// An accepted item is scanned from the input register; the result of its last byte is
// loaded into the result register and held there until the receiver takes it.
// Throughput: one item per cycle; a last byte waits only while the previous result
// is still stalled in the result register.
// Reset clears the valid flags and the scanner state; the first byte after reset starts a new event.
// Depends on tlvefl_pkg, tlvefl_scan, tlvefl_out_reg and the assertion header.
`include "tlv_event_field_lookup_assert.svh"

module tlv_event_field_lookup (
	input logic clk,
	input logic arst_n,
	input logic byte_valid,
	output logic byte_stall,
	input tlvefl_pkg::in_item_t byte_item,
	output logic result_valid,
	input logic result_stall,
	output tlvefl_pkg::out_item_t result_item
);

	logic valid_s1;
	tlvefl_pkg::in_item_t item_s1;
	logic advance;
	logic can_load;
	logic load;
	logic at_event_start;
	logic result_found;
	logic length_ok;
	tlvefl_pkg::out_item_t scan_result;

	assign advance = valid_s1 && (!item_s1.last_byte || can_load);
	assign load = advance && item_s1.last_byte;
	assign byte_stall = valid_s1 && !advance;
	assign result_found = result_valid && result_item.found;
	assign length_ok = (result_item.event_length >= 16'd8);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			item_s1 <= byte_item;
		end
	end

	tlvefl_scan u_scan (
		.clk(clk),
		.arst_n(arst_n),
		.advance(advance),
		.item(item_s1),
		.result(scan_result),
		.at_event_start(at_event_start)
	);

	tlvefl_out_reg u_out (
		.clk(clk),
		.arst_n(arst_n),
		.load(load),
		.d(scan_result),
		.can_load(can_load),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_item(result_item)
	);

	`TLVEFL_ASSERT_NXT(a_restart_after_last, clk, arst_n, load, at_event_start)
	`TLVEFL_ASSERT_IMP(a_no_stall_when_empty, clk, arst_n, !valid_s1, !byte_stall)
	`TLVEFL_ASSERT_IMP(a_found_needs_length, clk, arst_n, result_found, length_ok)

endmodule

// ===== verif/tlv_event_field_lookup_checker.sv =====
// Checker for the event field lookup block: watches both item channels, predicts
// the lookup result of every event and compares it with what the block returns.
// Depends on tlvefl_pkg.
module tlv_event_field_lookup_checker (
	input logic clk,
	input logic arst_n,
	input logic byte_valid,
	input logic byte_stall,
	input tlvefl_pkg::in_item_t byte_item,
	input logic result_valid,
	input logic result_stall,
	input tlvefl_pkg::out_item_t result_item,
	output int fail_count,
	output int results_pending
);

	logic [15:0] offset_q;
	logic [15:0] decl_len;
	logic [15:0] ev_kind;
	logic [15:0] target;
	logic [16:0] next_hdr;
	logic [15:0] el_type;
	logic [15:0] el_len;
	logic matched;
	logic [31:0] value_acc;
	logic [2:0] value_cnt;
	tlvefl_pkg::out_item_t lookups_due[$];

	function automatic void scan_element_byte(input logic [15:0] pos, input logic [7:0] b);
		logic [16:0] rel;
		logic [17:0] nxt;
		if (matched) begin
			if (value_cnt < tlvefl_pkg::VALUE_BYTES) begin
				value_acc = {value_acc[23:0], b};
				value_cnt = value_cnt + 3'd1;
			end
			return;
		end
		if (next_hdr == tlvefl_pkg::SCAN_DONE || {1'b0, pos} < next_hdr)
			return;
		rel = {1'b0, pos} - next_hdr;
		if (rel == 17'd0 && {1'b0, next_hdr} + 18'd4 > {2'b00, decl_len}) begin
			next_hdr = tlvefl_pkg::SCAN_DONE;
			return;
		end
		if (rel < 17'd2) begin
			el_type = {el_type[7:0], b};
		end else if (rel < 17'd4) begin
			el_len = {el_len[7:0], b};
			if (rel == 17'd3) begin
				if (el_type == target) begin
					matched = 1'b1;
				end else begin
					nxt = {1'b0, next_hdr} + 18'd4 + {2'b00, el_len};
					next_hdr = (nxt >= {1'b0, tlvefl_pkg::SCAN_DONE}) ?
						tlvefl_pkg::SCAN_DONE : nxt[16:0];
				end
			end
		end
	endfunction

	function automatic void predict_lookup_byte(input tlvefl_pkg::in_item_t it);
		logic [15:0] pos;
		logic [16:0] received;
		tlvefl_pkg::out_item_t r;
		pos = offset_q;
		if (pos == 16'd0) begin
			target = it.wanted_type;
			decl_len = '0;
			ev_kind = '0;
			next_hdr = 17'd4;
			el_type = '0;
			el_len = '0;
			matched = 1'b0;
			value_acc = '0;
			value_cnt = '0;
		end
		if (pos < 16'd2)
			ev_kind = {ev_kind[7:0], it.data_byte};
		else if (pos < 16'd4)
			decl_len = {decl_len[7:0], it.data_byte};
		else if (pos < decl_len)
			scan_element_byte(pos, it.data_byte);
		if (offset_q != tlvefl_pkg::OFFSET_MAX)
			offset_q = offset_q + 16'd1;
		if (!it.last_byte)
			return;

		received = {1'b0, pos} + 17'd1;
		r.found = matched;
		r.event_type = (received == 17'd1) ? {ev_kind[7:0], 8'h00} : ev_kind;
		if (received < 17'd3)
			r.event_length = '0;
		else if (received == 17'd3)
			r.event_length = {decl_len[7:0], 8'h00};
		else
			r.event_length = decl_len;
		r.element_value = '0;
		if (matched && value_cnt >= tlvefl_pkg::VALUE_BYTES)
			r.element_value = value_acc;
		else if (matched && value_cnt != 3'd0)
			r.element_value = value_acc << (8 * (4 - int'(value_cnt)));
		r.truncated = (received < 17'd4) || (received < {1'b0, r.event_length});
		lookups_due.push_back(r);
		offset_q = '0;
	endfunction

	function automatic void check_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", field, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		tlvefl_pkg::out_item_t want;
		if (!arst_n) begin
			offset_q = '0;
			decl_len = '0;
			ev_kind = '0;
			target = '0;
			next_hdr = '0;
			el_type = '0;
			el_len = '0;
			matched = 1'b0;
			value_acc = '0;
			value_cnt = '0;
			lookups_due.delete();
			fail_count = 0;
			results_pending <= 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (lookups_due.size() == 0) begin
					$error("result item with no lookup outstanding: 0x%0h", result_item);
					fail_count++;
				end else begin
					want = lookups_due.pop_front();
					check_field("found", 32'(want.found), 32'(result_item.found));
					check_field("element_value", want.element_value,
						result_item.element_value);
					check_field("event_type", 32'(want.event_type), 32'(result_item.event_type));
					check_field("event_length", 32'(want.event_length),
						32'(result_item.event_length));
					check_field("truncated", 32'(want.truncated), 32'(result_item.truncated));
				end
			end
			if (byte_valid && !byte_stall)
				predict_lookup_byte(byte_item);
			results_pending <= lookups_due.size();
		end
	end

endmodule

// ===== verif/tb_tlv_event_field_lookup.sv =====
// Testbench top for the event field lookup block: drives directed and random
// serialized events with bursty input and stalling output, and gives the verdict.
// Depends on tlvefl_pkg, tlv_event_field_lookup and tlv_event_field_lookup_checker.
module tb_tlv_event_field_lookup;

	localparam int CYCLE_LIMIT = 600000;
	localparam int HOLD_CYCLES = 400;
	localparam int RANDOM_BYTES = 1350;
	localparam int MIN_EVENTS = 60;

	typedef logic [7:0] byte_stream_t[$];

	logic clk;
	logic arst_n;
	logic byte_valid;
	logic byte_stall;
	tlvefl_pkg::in_item_t byte_item;
	logic result_valid;
	logic result_stall;
	tlvefl_pkg::out_item_t result_item;

	int fail_count;
	int results_pending;
	int cycle_count = 0;
	int burst_left;
	int bytes_sent;
	int events_sent;
	bit steady_sender;
	bit hold_request;

	tlv_event_field_lookup uut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.byte_item(byte_item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_item(result_item)
	);

	tlv_event_field_lookup_checker lookup_checker (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.byte_item(byte_item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_item(result_item),
		.fail_count(fail_count),
		.results_pending(results_pending)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tlv_event_field_lookup: mismatch");
			$finish;
		end
	end

	function automatic void put16(ref byte_stream_t s, input logic [15:0] v);
		s.push_back(v[15:8]);
		s.push_back(v[7:0]);
	endfunction

	function automatic void put_element(ref byte_stream_t s, input logic [15:0] etype,
			input logic [15:0] plen, input int fill);
		put16(s, etype);
		put16(s, plen);
		repeat (fill) s.push_back(8'($urandom));
	endfunction

	function automatic void set_length(ref byte_stream_t s, input int v);
		s[2] = v[15:8];
		s[3] = v[7:0];
	endfunction

	function automatic void cut_stream(ref byte_stream_t s, input int keep);
		while (s.size() > keep)
			void'(s.pop_back());
	endfunction

	task automatic send_byte(input tlvefl_pkg::in_item_t it);
		int gap;
		if (!steady_sender) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 40);
				gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
				byte_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end else begin
				burst_left--;
			end
		end
		byte_valid <= 1'b1;
		byte_item <= it;
		@(posedge clk);
		while (byte_stall) @(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_event(input byte_stream_t s, input logic [15:0] wanted);
		tlvefl_pkg::in_item_t it;
		for (int i = 0; i < s.size(); i++) begin
			it.data_byte = s[i];
			it.wanted_type = (i == 0) ? wanted : 16'($urandom);
			it.last_byte = (i == s.size() - 1);
			send_byte(it);
		end
		events_sent++;
	endtask

	task automatic send_noise_event(input int max_len);
		byte_stream_t s;
		repeat ($urandom_range(1, max_len)) s.push_back(8'($urandom));
		send_event(s, 16'($urandom));
	endtask

	// Well-formed events with random content, with some declared lengths and
	// stream ends deliberately wrong.
	task automatic send_random_event();
		byte_stream_t s;
		logic [15:0] wanted;
		logic [15:0] etype;
		logic [15:0] plen;
		int nel;
		int hit;
		wanted = 16'($urandom);
		nel = $urandom_range(0, 5);
		hit = $urandom_range(0, nel + 1);
		put16(s, 16'($urandom));
		put16(s, 16'h0000);
		for (int i = 0; i < nel; i++) begin
			if (i == hit)
				etype = wanted;
			else if ($urandom_range(0, 1) == 1)
				etype = wanted ^ (16'h0001 << $urandom_range(0, 15));
			else
				etype = 16'($urandom);
			case ($urandom_range(0, 9))
				6, 7: plen = 16'($urandom_range(0, 3));
				8: plen = 16'($urandom_range(9, 40));
				9: plen = 16'h0000;
				default: plen = 16'($urandom_range(0, 8));
			endcase
			put_element(s, etype, plen, int'(plen));
		end
		case ($urandom_range(0, 9))
			0: set_length(s, $urandom_range(0, 7));
			1: set_length(s, $urandom_range(0, 65535));
			2: set_length(s, (s.size() > 6) ? s.size() - $urandom_range(1, 6) : s.size());
			3: set_length(s, s.size() + $urandom_range(1, 8));
			default: set_length(s, s.size());
		endcase
		case ($urandom_range(0, 9))
			0, 1: cut_stream(s, $urandom_range(1, s.size()));
			2: repeat ($urandom_range(1, 6)) s.push_back(8'($urandom));
			default: ;
		endcase
		send_event(s, wanted);
	endtask

	task automatic drain_results();
		byte_valid <= 1'b0;
		@(posedge clk);
		while (results_pending != 0) @(posedge clk);
	endtask

	initial begin
		int mode;
		int span;
		result_stall = 1'b0;
		forever begin
			if (hold_request) begin
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
			end else begin
				mode = $urandom_range(0, 3);
				span = $urandom_range(20, 150);
				repeat (span) begin
					case (mode)
						0: result_stall <= 1'b0;
						1: result_stall <= ($urandom_range(0, 3) == 0);
						2: result_stall <= ($urandom_range(0, 3) != 0);
						default: result_stall <= ~result_stall;
					endcase
					@(posedge clk);
					if (hold_request)
						break;
				end
			end
		end
	end

	initial begin
		byte_stream_t s;
		clk = 1'b0;
		arst_n = 1'b0;
		byte_valid = 1'b0;
		byte_item = '0;
		hold_request = 1'b0;
		steady_sender = 1'b0;
		burst_left = 0;
		bytes_sent = 0;
		events_sent = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Streams that end inside the header or right at its end.
		s = {8'hAB};
		send_event(s, 16'h0000);
		s = {8'hFF, 8'hFF};
		send_event(s, 16'hFFFF);
		s = {8'h12, 8'h34, 8'hFF};
		send_event(s, 16'h1234);
		s.delete();
		put16(s, 16'hFFFF);
		put16(s, 16'h0004);
		send_event(s, 16'hFFFF);

		// A declared length under eight hides a matching element.
		s.delete();
		put16(s, 16'h0001);
		put16(s, 16'h0000);
		put_element(s, 16'h0042, 16'd4, 4);
		set_length(s, 7);
		send_event(s, 16'h0042);

		// Match on the first element with all-ones value bytes.
		s.delete();
		put16(s, 16'h8000);
		put16(s, 16'h0000);
		put_element(s, 16'h0000, 16'd4, 0);
		repeat (4) s.push_back(8'hFF);
		set_length(s, s.size());
		send_event(s, 16'h0000);

		// Match after skipped elements; the short payload runs into the next header.
		s.delete();
		put16(s, 16'h7FFF);
		put16(s, 16'h0000);
		put_element(s, 16'h1234, 16'd2, 2);
		put_element(s, 16'hFFFE, 16'd0, 0);
		put_element(s, 16'hFFFF, 16'd3, 3);
		put_element(s, 16'h0000, 16'd1, 1);
		set_length(s, s.size());
		send_event(s, 16'hFFFF);

		// Value bytes past the declared length read as zero.
		s.delete();
		put16(s, 16'h0102);
		put16(s, 16'h0000);
		put_element(s, 16'h0007, 16'd8, 8);
		set_length(s, 10);
		send_event(s, 16'h0007);

		// Matching element with an empty payload at the very end of the event.
		s.delete();
		put16(s, 16'h0203);
		put16(s, 16'h0000);
		put_element(s, 16'h0003, 16'd0, 0);
		set_length(s, 8);
		repeat (3) s.push_back(8'($urandom));
		send_event(s, 16'h0003);

		// The second element header does not fit below the declared length.
		s.delete();
		put16(s, 16'h0304);
		put16(s, 16'h0000);
		put_element(s, 16'h0001, 16'd0, 0);
		put_element(s, 16'h0002, 16'd4, 4);
		set_length(s, 10);
		send_event(s, 16'h0002);

		// Stream ends inside the matched value, then inside an element header.
		s.delete();
		put16(s, 16'h0405);
		put16(s, 16'h0000);
		put_element(s, 16'h00AA, 16'd4, 4);
		set_length(s, s.size());
		cut_stream(s, 10);
		send_event(s, 16'h00AA);
		s.delete();
		put16(s, 16'h0506);
		put16(s, 16'h0000);
		put_element(s, 16'h0009, 16'd4, 4);
		set_length(s, s.size());
		cut_stream(s, 6);
		send_event(s, 16'h0009);

		// An all-ones payload length pushes the next element out of reach.
		s.delete();
		put16(s, 16'h0607);
		put16(s, 16'h0000);
		put_element(s, 16'h0005, 16'hFFFF, 2);
		put_element(s, 16'h0006, 16'd4, 4);
		set_length(s, s.size());
		send_event(s, 16'h0006);

		// Zero declared length: everything after the header is ignored.
		s.delete();
		put16(s, 16'h0000);
		put16(s, 16'h0000);
		repeat (8) s.push_back(8'h00);
		send_event(s, 16'h0000);

		// All-ones header on a short stream.
		s = {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
		send_event(s, 16'hFFFF);

		// Maximum declared length on a short stream.
		s.delete();
		put16(s, 16'hC0DE);
		put16(s, 16'hFFFF);
		put_element(s, 16'h1111, 16'hFFF0, 6);
		put_element(s, 16'h2222, 16'd4, 4);
		send_event(s, 16'h2222);
		drain_results();

		bytes_sent = 0;
		while (bytes_sent < RANDOM_BYTES || events_sent < MIN_EVENTS + 16) begin
			if (events_sent % 37 == 0)
				drain_results();
			if (events_sent == 40) begin
				hold_request = 1'b1;
				steady_sender = 1'b1;
				repeat (30) send_noise_event(3);
			end
			steady_sender = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 4) == 0)
				send_noise_event(24);
			else
				send_random_event();
		end
		steady_sender = 1'b0;

		drain_results();
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("tlv_event_field_lookup: match");
		else
			$display("tlv_event_field_lookup: mismatch");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+src
src/tlvefl_pkg.sv
src/tlvefl_scan.sv
src/tlvefl_out_reg.sv
src/tlv_event_field_lookup.sv
verif/tlv_event_field_lookup_checker.sv
verif/tb_tlv_event_field_lookup.sv
